### rtl/core/apd_pkg.sv
// shared types and constants for the age priority deque
// no dependencies; used by age_priority_deque_top and its testbench
`timescale 1ns / 1ps

package apd_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int TAG_BITS_DEF = 16;

   localparam int OP_W       = 2;
   localparam int TAG_PORT_W = 16;
   localparam int AGE_W      = 7;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 5;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_BACK  = 2'd0,
      OP_PUSH_FRONT = 2'd1,
      OP_PUSH_PRIO  = 2'd2,
      OP_POP        = 2'd3
   } apd_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } apd_status_type;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_START  = 5'b00010,
      S_POP_RD = 5'b00100,
      S_SCAN   = 5'b01000,
      S_DONE   = 5'b10000
   } apd_state_type;

endpackage

### rtl/core/apd_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module apd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/age_priority_deque_top.sv
// age priority deque: control sequencer around a circular buffer in one ram
// depends on apd_pkg and apd_ram
`timescale 1ns / 1ps

// A bounded deque of (tag, age) entries kept in a circular buffer in one ram with
// a registered read. One request beat is taken at a time. Push back, push front,
// a push when full and a pop when empty go from S_START to S_DONE; a pop passes
// through S_POP_RD as well because it waits on the ram read of the head entry. A
// priority push walks the ram from the head, one entry per cycle, comparing ages
// and rippling displaced entries one slot toward the tail. A new request is taken
// while the last result beat still waits in the output register.
module age_priority_deque_top #(
   parameter int CAPACITY = apd_pkg::CAPACITY_DEF,
   parameter int TAG_BITS = apd_pkg::TAG_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [apd_pkg::OP_W-1:0]        req_operation,
   input  logic [apd_pkg::TAG_PORT_W-1:0]  req_patient_tag,
   input  logic [apd_pkg::AGE_W-1:0]       req_age,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [apd_pkg::STATUS_W-1:0]    rsp_status,
   output logic [apd_pkg::TAG_PORT_W-1:0]  rsp_popped_tag,
   output logic [apd_pkg::AGE_W-1:0]       rsp_popped_age,
   output logic [apd_pkg::OCC_W-1:0]       rsp_occupancy
);

   localparam int PTR_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int DATA_W = TAG_BITS + apd_pkg::AGE_W;
   localparam int TP_W   = apd_pkg::TAG_PORT_W;

   apd_pkg::apd_state_type  state_ff, state_in;
   apd_pkg::apd_op_type     op_ff, op_in;
   apd_pkg::apd_status_type res_status_ff, res_status_in;

   logic [PTR_W-1:0]          head_ff, head_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic                      ins_ff, ins_in;
   logic [TAG_BITS-1:0]       tag_ff, tag_in;
   logic [apd_pkg::AGE_W-1:0] age_ff, age_in;
   logic [DATA_W-1:0]         held_ff, held_in;
   logic [TP_W-1:0]           res_tag_ff, res_tag_in;
   logic [apd_pkg::AGE_W-1:0] res_age_ff, res_age_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [apd_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [TP_W-1:0]              rsp_tag_ff, rsp_tag_in;
   logic [apd_pkg::AGE_W-1:0]    rsp_age_ff, rsp_age_in;
   logic [apd_pkg::OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;

   logic                      wr_en, rd_en;
   logic [PTR_W-1:0]          wr_addr, rd_addr;
   logic [DATA_W-1:0]         wr_data, rd_data;
   logic [TAG_BITS-1:0]       rd_tag;
   logic [apd_pkg::AGE_W-1:0] rd_age;

   logic [TAG_BITS+TP_W-1:0]       tag_req_ext, tag_rd_ext;
   logic [CNT_W+apd_pkg::OCC_W-1:0] occ_ext;
   logic                            req_beat, rsp_free, full, empty;

   function automatic logic [PTR_W-1:0] slot_addr(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + {1'b0, off};
      if (sum >= (CNT_W+1)'(CAPACITY)) begin
         sum = sum - (CNT_W+1)'(CAPACITY);
      end
      return sum[PTR_W-1:0];
   endfunction

   apd_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_tag = rd_data[DATA_W-1:apd_pkg::AGE_W];
   assign rd_age = rd_data[apd_pkg::AGE_W-1:0];

   assign tag_req_ext = {{TAG_BITS{1'b0}}, req_patient_tag};
   assign tag_rd_ext  = {{TP_W{1'b0}}, rd_tag};
   assign occ_ext     = {{apd_pkg::OCC_W{1'b0}}, count_ff};

   assign req_ready = (state_ff == apd_pkg::S_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      tag_in        = tag_ff;
      age_in        = age_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      ins_in        = ins_ff;
      held_in       = held_ff;
      res_status_in = res_status_ff;
      res_tag_in    = res_tag_ff;
      res_age_in    = res_age_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_age_in    = rsp_age_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_addr(head_ff, idx_ff);
      wr_data       = held_ff;
      rd_en         = 1'b0;
      rd_addr       = head_ff;

      unique case (state_ff)
         apd_pkg::S_IDLE: begin
            if (req_beat) begin
               op_in    = apd_pkg::apd_op_type'(req_operation);
               tag_in   = tag_req_ext[TAG_BITS-1:0];
               age_in   = req_age;
               state_in = apd_pkg::S_START;
            end
         end

         apd_pkg::S_START: begin
            res_status_in = apd_pkg::ST_DONE;
            res_tag_in    = '0;
            res_age_in    = '0;
            state_in      = apd_pkg::S_DONE;
            if (op_ff == apd_pkg::OP_POP) begin
               if (empty) begin
                  res_status_in = apd_pkg::ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  state_in = apd_pkg::S_POP_RD;
               end
            end else if (full) begin
               res_status_in = apd_pkg::ST_FULL;
            end else begin
               unique case (op_ff)
                  apd_pkg::OP_PUSH_BACK: begin
                     wr_en    = 1'b1;
                     wr_addr  = slot_addr(head_ff, count_ff);
                     wr_data  = {tag_ff, age_ff};
                     count_in = count_ff + CNT_W'(1);
                  end
                  apd_pkg::OP_PUSH_FRONT: begin
                     head_in  = (head_ff == '0) ? PTR_W'(CAPACITY - 1)
                                                : head_ff - PTR_W'(1);
                     wr_en    = 1'b1;
                     wr_addr  = head_in;
                     wr_data  = {tag_ff, age_ff};
                     count_in = count_ff + CNT_W'(1);
                  end
                  default: begin
                     rd_en    = 1'b1;
                     idx_in   = '0;
                     ins_in   = 1'b0;
                     held_in  = {tag_ff, age_ff};
                     state_in = apd_pkg::S_SCAN;
                  end
               endcase
            end
         end

         apd_pkg::S_POP_RD: begin
            res_tag_in = tag_rd_ext[TP_W-1:0];
            res_age_in = rd_age;
            head_in    = slot_addr(head_ff, CNT_W'(1));
            count_in   = count_ff - CNT_W'(1);
            state_in   = apd_pkg::S_DONE;
         end

         apd_pkg::S_SCAN: begin
            if (idx_ff == count_ff) begin
               // tail slot takes whichever entry is still held
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               state_in = apd_pkg::S_DONE;
            end else begin
               if (ins_ff || (rd_age < age_ff)) begin
                  wr_en   = 1'b1;
                  held_in = rd_data;
                  ins_in  = 1'b1;
               end
               rd_en   = 1'b1;
               rd_addr = slot_addr(head_ff, idx_ff + CNT_W'(1));
               idx_in  = idx_ff + CNT_W'(1);
            end
         end

         apd_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_tag_in    = res_tag_ff;
               rsp_age_in    = res_age_ff;
               rsp_occ_in    = occ_ext[apd_pkg::OCC_W-1:0];
               state_in      = apd_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = apd_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= apd_pkg::S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tag_ff        <= tag_in;
      age_ff        <= age_in;
      idx_ff        <= idx_in;
      ins_ff        <= ins_in;
      held_ff       <= held_in;
      res_status_ff <= res_status_in;
      res_tag_ff    <= res_tag_in;
      res_age_ff    <= res_age_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_age_ff    <= rsp_age_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_popped_tag = rsp_tag_ff;
   assign rsp_popped_age = rsp_age_ff;
   assign rsp_occupancy  = rsp_occ_ff;

endmodule

### dv/age_priority_deque_top_tb.sv
// testbench for age_priority_deque_top: directed, stall and random deque traffic,
// every result beat checked against a local deque predictor
// depends on apd_pkg and age_priority_deque_top
`timescale 1ns / 1ps

module age_priority_deque_top_tb;

   localparam int DEPTH = apd_pkg::CAPACITY_DEF;

   typedef struct packed {
      apd_pkg::apd_status_type        status;
      logic [apd_pkg::TAG_PORT_W-1:0] tag;
      logic [apd_pkg::AGE_W-1:0]      age;
      logic [apd_pkg::OCC_W-1:0]      occ;
   } deque_outcome_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [apd_pkg::OP_W-1:0]       req_operation = '0;
   logic [apd_pkg::TAG_PORT_W-1:0] req_patient_tag = '0;
   logic [apd_pkg::AGE_W-1:0]      req_age = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [apd_pkg::STATUS_W-1:0]   rsp_status;
   logic [apd_pkg::TAG_PORT_W-1:0] rsp_popped_tag;
   logic [apd_pkg::AGE_W-1:0]      rsp_popped_age;
   logic [apd_pkg::OCC_W-1:0]      rsp_occupancy;

   logic [apd_pkg::TAG_PORT_W-1:0] held_tags [DEPTH];
   logic [apd_pkg::AGE_W-1:0]      held_ages [DEPTH];
   int                             held_count = 0;
   deque_outcome_type              deque_outcomes [$];

   int error_count = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int full_drops = 0;
   int empty_pops = 0;
   int pops_done = 0;
   bit sender_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;
   int long_hold_req = 0;
   int stall_left = 0;

   age_priority_deque_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_patient_tag (req_patient_tag),
      .req_age         (req_age),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_popped_tag  (rsp_popped_tag),
      .rsp_popped_age  (rsp_popped_age),
      .rsp_occupancy   (rsp_occupancy)
   );

   always #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("%0t: timeout with %0d results outstanding", $time, deque_outcomes.size());
      $display("simulation failed");
      $finish;
   end

   function automatic deque_outcome_type apply_deque_op(
      apd_pkg::apd_op_type op,
      logic [apd_pkg::TAG_PORT_W-1:0] tag,
      logic [apd_pkg::AGE_W-1:0] age);
      deque_outcome_type res;
      int                pos;
      int                i;
      bit                found;
      res = '0;
      res.status = apd_pkg::ST_DONE;
      if (op == apd_pkg::OP_POP) begin
         if (held_count == 0) begin
            res.status = apd_pkg::ST_EMPTY;
            empty_pops++;
         end else begin
            res.tag = held_tags[0];
            res.age = held_ages[0];
            for (i = 1; i < held_count; i++) begin
               held_tags[i-1] = held_tags[i];
               held_ages[i-1] = held_ages[i];
            end
            held_count--;
            pops_done++;
         end
      end else if (held_count >= DEPTH) begin
         res.status = apd_pkg::ST_FULL;
         full_drops++;
      end else begin
         pos = held_count;
         if (op == apd_pkg::OP_PUSH_FRONT) begin
            pos = 0;
         end else if (op == apd_pkg::OP_PUSH_PRIO) begin
            found = 1'b0;
            // in front of the first strictly younger entry from the head
            for (i = 0; i < held_count; i++) begin
               if (!found && held_ages[i] < age) begin
                  pos = i;
                  found = 1'b1;
               end
            end
         end
         for (i = held_count; i > pos; i--) begin
            held_tags[i] = held_tags[i-1];
            held_ages[i] = held_ages[i-1];
         end
         held_tags[pos] = tag;
         held_ages[pos] = age;
         held_count++;
      end
      res.occ = apd_pkg::OCC_W'(held_count);
      return res;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      deque_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (deque_outcomes.size() == 0) begin
            error_count++;
            $display("%0t: result beat with nothing expected, expected none, actual status %0d",
                     $time, rsp_status);
         end else begin
            want = deque_outcomes.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("popped_tag", want.tag, rsp_popped_tag);
            check_field("popped_age", want.age, rsp_popped_age);
            check_field("occupancy", want.occ, rsp_occupancy);
            beats_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (long_hold_req > 0) begin
            stall_left = long_hold_req;
            long_hold_req = 0;
         end else if (stall_left == 0 && rsp_idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 9);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // valid stays up across back-to-back beats, dropped only for a gap or by pause_sender
   task automatic send_beat(apd_pkg::apd_op_type op,
                            logic [apd_pkg::TAG_PORT_W-1:0] tag,
                            logic [apd_pkg::AGE_W-1:0] age);
      int gap;
      gap = 0;
      if (sender_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_patient_tag <= tag;
      req_age <= age;
      do @(posedge clock); while (!req_ready);
      deque_outcomes.push_back(apply_deque_op(op, tag, age));
      beats_sent++;
   endtask

   task automatic pause_sender();
      req_valid <= 1'b0;
      while (deque_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic send_random(int pop_pct, bit prio_only);
      apd_pkg::apd_op_type       op;
      logic [apd_pkg::AGE_W-1:0] age;
      int                        pick;
      pick = $urandom_range(0, 3);
      if ($urandom_range(0, 99) < pop_pct) op = apd_pkg::OP_POP;
      else if (prio_only || pick >= 2) op = apd_pkg::OP_PUSH_PRIO;
      else op = apd_pkg::apd_op_type'(pick);
      case ($urandom_range(0, 3))
         0: age = apd_pkg::AGE_W'($urandom_range(40, 43));
         1: age = $urandom_range(0, 1) ? 7'd127 : 7'd0;
         default: age = apd_pkg::AGE_W'($urandom_range(0, 127));
      endcase
      send_beat(op, apd_pkg::TAG_PORT_W'($urandom), age);
   endtask

   task automatic test_basic_ops();
      sender_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_beat(apd_pkg::OP_POP, '0, '0);
      send_beat(apd_pkg::OP_PUSH_BACK, 16'hffff, 7'd127);
      send_beat(apd_pkg::OP_PUSH_FRONT, 16'h0000, 7'd0);
      send_beat(apd_pkg::OP_PUSH_PRIO, 16'h1234, 7'd127);
      send_beat(apd_pkg::OP_PUSH_PRIO, 16'haaaa, 7'd0);
      send_beat(apd_pkg::OP_PUSH_BACK, 16'h5555, 7'd64);
      repeat (6) send_beat(apd_pkg::OP_POP, 16'hffff, 7'd127);
   endtask

   task automatic test_fifo_ties();
      send_beat(apd_pkg::OP_PUSH_PRIO, 16'h0001, 7'd50);
      send_beat(apd_pkg::OP_PUSH_PRIO, 16'h0002, 7'd50);
      send_beat(apd_pkg::OP_PUSH_PRIO, 16'h0003, 7'd90);
      send_beat(apd_pkg::OP_PUSH_PRIO, 16'h0004, 7'd50);
      send_beat(apd_pkg::OP_PUSH_PRIO, 16'h0005, 7'd0);
      repeat (5) send_beat(apd_pkg::OP_POP, '0, '0);
   endtask

   task automatic test_fill_under_stall();
      int i;
      sender_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      long_hold_req = 200;
      for (i = 0; i < DEPTH; i++) begin
         send_beat(apd_pkg::apd_op_type'($urandom_range(0, 2)),
                   apd_pkg::TAG_PORT_W'($urandom),
                   apd_pkg::AGE_W'($urandom_range(0, 127)));
      end
      send_beat(apd_pkg::OP_PUSH_BACK, 16'hbeef, 7'd1);
      send_beat(apd_pkg::OP_PUSH_FRONT, 16'h0f0f, 7'd126);
      send_beat(apd_pkg::OP_PUSH_PRIO, 16'hffff, 7'd127);
      pause_sender();
      for (i = 0; i <= DEPTH; i++) send_beat(apd_pkg::OP_POP, '0, '0);
      pause_sender();
   endtask

   task automatic test_random_mix(int n_items);
      int sent;
      int run_len;
      int pop_pct;
      bit prio_only;
      sent = 0;
      while (sent < n_items) begin
         run_len = $urandom_range(20, 60);
         case ($urandom_range(0, 3))
            0: pop_pct = 15;
            1: pop_pct = 75;
            default: pop_pct = 45;
         endcase
         prio_only = ($urandom_range(0, 2) == 0);
         sender_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         repeat (run_len) begin
            send_random(pop_pct, prio_only);
            sent++;
         end
      end
   endtask

   task automatic test_back_to_back(int n_items);
      sender_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (n_items) send_random(45, 1'b0);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_ops();
      test_fifo_ties();
      test_fill_under_stall();
      test_random_mix(850);
      test_back_to_back(150);
      pause_sender();
      repeat (40) @(posedge clock);
      if (deque_outcomes.size() != 0) begin
         error_count++;
         $display("%0t: results left over, expected 0, actual %0d", $time,
                  deque_outcomes.size());
      end
      $display("covered %0d beats (%0d checked): %0d pops, %0d pops on empty, %0d full drops",
               beats_sent, beats_checked, pops_done, empty_pops, full_drops);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/apd_pkg.sv
rtl/core/apd_ram.sv
rtl/core/age_priority_deque_top.sv
dv/age_priority_deque_top_tb.sv
